### src/ilist_pkg.sv
package ilist_pkg;

  localparam int CAPACITY  = 64;
  localparam int ELEM_BITS = 32;

  localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNTW = $clog2(CAPACITY + 1);
  // common width for comparing the 7-bit input index against positions and the count
  localparam int CMPW = (CNTW > 7) ? CNTW : 7;

  // cells are reduced in groups of eight
  localparam int GRP   = 8;
  localparam int GJW   = 3;
  localparam int NGRP  = (CAPACITY + GRP - 1) / GRP;
  localparam int NPAD  = NGRP * GRP;
  localparam int GSELW = (NGRP > 1) ? $clog2(NGRP) : 1;

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_INSERT = 3'd2,
    OP_REMOVE = 3'd3,
    OP_FIND   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [6:0]  element_index;
    logic [31:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_value;
    logic [5:0]  found_index;
    logic [6:0]  element_count;
  } out_item_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    logic                 wr_en;
    logic                 ins_en;
    logic                 rem_en;
    logic [CMPW-1:0]      idx;
    logic [CMPW-1:0]      count;
    logic [ELEM_BITS-1:0] val;
  } cell_ctrl_t;

  typedef struct packed {
    logic                 found;
    logic [IDXW-1:0]      fidx;
    logic [ELEM_BITS-1:0] rd;
  } find_res_t;

endpackage

### src/ilist_cell.sv
module ilist_cell (
  input  logic                           clk_i,
  input  logic [ilist_pkg::IDXW-1:0]     pos_i,
  input  ilist_pkg::cell_ctrl_t          ctrl_i,
  input  logic [ilist_pkg::ELEM_BITS-1:0] prev_i,
  input  logic [ilist_pkg::ELEM_BITS-1:0] next_i,
  output logic [ilist_pkg::ELEM_BITS-1:0] data_o,
  output logic                           match_o,
  output logic [ilist_pkg::ELEM_BITS-1:0] rd_o
);

  logic [ilist_pkg::ELEM_BITS-1:0] data_q, data_d;
  logic [ilist_pkg::CMPW-1:0]      pos_w;
  logic                            at_idx, above;

  assign pos_w  = ilist_pkg::CMPW'(pos_i);
  assign at_idx = (pos_w == ctrl_i.idx);
  assign above  = (pos_w > ctrl_i.idx);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.wr_en && at_idx) begin
      data_d = ctrl_i.val;
    end else if (ctrl_i.ins_en) begin
      // open a gap at the index, move the tail up
      if (at_idx) begin
        data_d = ctrl_i.val;
      end else if (above) begin
        data_d = prev_i;
      end
    end else if (ctrl_i.rem_en && (at_idx || above)) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (pos_w < ctrl_i.count) && (data_q == ctrl_i.val);
  assign rd_o    = at_idx ? data_q : '0;

endmodule

### src/ilist_resolve.sv
module ilist_resolve (
  input  logic [ilist_pkg::NPAD-1:0]                       match_i,
  input  logic [ilist_pkg::NGRP-1:0][ilist_pkg::ELEM_BITS-1:0] rdg_i,
  output ilist_pkg::find_res_t                             res_o
);

  logic [ilist_pkg::NGRP-1:0]      grp_any;
  logic [ilist_pkg::GSELW-1:0]     gsel;
  logic [ilist_pkg::GRP-1:0]       gvec;
  logic [ilist_pkg::GJW-1:0]       jsel;
  logic [ilist_pkg::ELEM_BITS-1:0] rd_or;

  always_comb begin
    for (int g = 0; g < ilist_pkg::NGRP; g++) begin
      grp_any[g] = |match_i[g*ilist_pkg::GRP +: ilist_pkg::GRP];
    end
  end

  // lowest group with a hit, then lowest hit inside it
  always_comb begin
    gsel = '0;
    for (int g = ilist_pkg::NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        gsel = ilist_pkg::GSELW'(g);
      end
    end
  end

  assign gvec = match_i[gsel*ilist_pkg::GRP +: ilist_pkg::GRP];

  always_comb begin
    jsel = '0;
    for (int j = ilist_pkg::GRP - 1; j >= 0; j--) begin
      if (gvec[j]) begin
        jsel = ilist_pkg::GJW'(j);
      end
    end
  end

  always_comb begin
    rd_or = '0;
    for (int g = 0; g < ilist_pkg::NGRP; g++) begin
      rd_or = rd_or | rdg_i[g];
    end
  end

  assign res_o.found = |grp_any;
  assign res_o.fidx  = ilist_pkg::IDXW'({gsel, jsel});
  assign res_o.rd    = rd_or;

endmodule

### src/indexed_list_insert_remove_find.sv
// Indexed list with insert, remove, read, overwrite and find.
// Input channel in_valid_i / in_stall_o carries one operation per transaction;
// output channel out_valid_o / out_stall_i returns exactly one result for it.
// Elements live in a chain of cells, one element per cell. Overwrite, insert
// and remove update every cell in the cycle the transaction is accepted, each
// cell taking its own value, the new value, or its lower or upper neighbour's value.
// Every cell also compares against the search value and offers its contents
// for a read; those are reduced in two registered steps (groups of eight,
// then across groups).
// After acceptance the item passes through the S_RED and S_OUT states, the
// result being registered on leaving S_RED. One item is in flight at a time,
// so a new item is taken only once the result has been handed over.
// While the result waits under out_stall_i the block holds it unchanged and
// keeps in_stall_o high.
// Reset clears the element count; cell contents are undefined until written,
// and no position at or above the count is ever read.
module indexed_list_insert_remove_find (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ilist_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ilist_pkg::out_item_t out_item_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RED  = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [ilist_pkg::CNTW-1:0] count_q, count_d;
  logic                       in_acc;
  logic [ilist_pkg::CMPW-1:0] idx_w, cnt_w;
  logic                       rw_ok;
  logic                       wr_en, ins_en, rem_en, rd_keep, is_find;
  logic [1:0]                 status;
  ilist_pkg::cell_ctrl_t      ctrl;

  logic [ilist_pkg::CAPACITY-1:0][ilist_pkg::ELEM_BITS-1:0] cell_data;
  logic [ilist_pkg::NPAD-1:0]                                match_w;
  logic [ilist_pkg::NPAD-1:0][ilist_pkg::ELEM_BITS-1:0]     rd_w;
  logic [ilist_pkg::NGRP-1:0][ilist_pkg::ELEM_BITS-1:0]     rdg_d;

  // first reduction step
  logic [ilist_pkg::NPAD-1:0]                            match_q;
  logic [ilist_pkg::NGRP-1:0][ilist_pkg::ELEM_BITS-1:0]  rdg_q;
  logic [1:0]                                            status_q;
  logic                                                  rd_keep_q, find_q;

  ilist_pkg::find_res_t res;
  ilist_pkg::out_item_t out_q, out_d;

  assign in_acc = in_valid_i && (state_q == S_IDLE);
  assign idx_w  = ilist_pkg::CMPW'(in_item_i.element_index);
  assign cnt_w  = ilist_pkg::CMPW'(count_q);
  assign rw_ok  = idx_w < cnt_w;

  always_comb begin
    wr_en   = 1'b0;
    ins_en  = 1'b0;
    rem_en  = 1'b0;
    rd_keep = 1'b0;
    is_find = 1'b0;
    status  = ilist_pkg::ST_OK;
    case (in_item_i.operation)
      ilist_pkg::OP_READ: begin
        rd_keep = rw_ok;
        if (!rw_ok) status = ilist_pkg::ST_RANGE;
      end
      ilist_pkg::OP_WRITE: begin
        wr_en = rw_ok;
        if (!rw_ok) status = ilist_pkg::ST_RANGE;
      end
      ilist_pkg::OP_INSERT: begin
        if (idx_w > cnt_w) begin
          status = ilist_pkg::ST_RANGE;
        end else if (cnt_w == ilist_pkg::CMPW'(ilist_pkg::CAPACITY)) begin
          status = ilist_pkg::ST_FULL;
        end else begin
          ins_en = 1'b1;
        end
      end
      ilist_pkg::OP_REMOVE: begin
        rem_en  = rw_ok;
        rd_keep = rw_ok;
        if (!rw_ok) status = ilist_pkg::ST_RANGE;
      end
      ilist_pkg::OP_FIND: begin
        is_find = 1'b1;
      end
      default: ;
    endcase
  end

  assign ctrl.wr_en  = in_acc && wr_en;
  assign ctrl.ins_en = in_acc && ins_en;
  assign ctrl.rem_en = in_acc && rem_en;
  assign ctrl.idx    = idx_w;
  assign ctrl.count  = cnt_w;
  assign ctrl.val    = in_item_i.element_value[ilist_pkg::ELEM_BITS-1:0];

  for (genvar i = 0; i < ilist_pkg::NPAD; i++) begin : g_cell
    if (i < ilist_pkg::CAPACITY) begin : g_live
      logic [ilist_pkg::ELEM_BITS-1:0] prev_w, next_w;
      if (i == 0) begin : g_first
        assign prev_w = '0;
      end else begin : g_mid_lo
        assign prev_w = cell_data[i-1];
      end
      if (i == ilist_pkg::CAPACITY - 1) begin : g_last
        assign next_w = '0;
      end else begin : g_mid_hi
        assign next_w = cell_data[i+1];
      end
      ilist_cell u_cell (
        .clk_i   (clk_i),
        .pos_i   (ilist_pkg::IDXW'(i)),
        .ctrl_i  (ctrl),
        .prev_i  (prev_w),
        .next_i  (next_w),
        .data_o  (cell_data[i]),
        .match_o (match_w[i]),
        .rd_o    (rd_w[i])
      );
    end else begin : g_pad
      assign match_w[i] = 1'b0;
      assign rd_w[i]    = '0;
    end
  end

  always_comb begin
    for (int g = 0; g < ilist_pkg::NGRP; g++) begin
      rdg_d[g] = '0;
      for (int j = 0; j < ilist_pkg::GRP; j++) begin
        rdg_d[g] = rdg_d[g] | rd_w[g*ilist_pkg::GRP + j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      match_q  <= match_w;
      rdg_q    <= rdg_d;
      status_q <= status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_keep_q <= 1'b0;
      find_q    <= 1'b0;
    end else if (in_acc) begin
      rd_keep_q <= rd_keep;
      find_q    <= is_find;
    end
  end

  ilist_resolve u_resolve (
    .match_i (match_q),
    .rdg_i   (rdg_q),
    .res_o   (res)
  );

  always_comb begin
    count_d = count_q;
    if (ctrl.ins_en) begin
      count_d = count_q + ilist_pkg::CNTW'(1);
    end else if (ctrl.rem_en) begin
      count_d = count_q - ilist_pkg::CNTW'(1);
    end
  end

  always_comb begin
    out_d.status        = status_q;
    out_d.result_value  = rd_keep_q ? 32'(res.rd) : '0;
    out_d.found_index   = '0;
    out_d.element_count = 7'(count_q);
    if (find_q) begin
      out_d.status = res.found ? ilist_pkg::ST_OK : ilist_pkg::ST_MISSING;
      if (res.found) out_d.found_index = 6'(res.fidx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RED) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_RED;
      S_RED:   state_d = S_OUT;
      S_OUT:   if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_item_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ilist_pkg::CNTW'(ilist_pkg::CAPACITY))
    else $error("element count above capacity");

  a_count_moves_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_RED) |-> $stable(count_q))
    else $error("element count changed without an accepted transaction");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (in_stall_o && !out_valid_o))
    else $error("new transaction taken while one is in flight");

  a_found_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && find_q && (out_item_o.status == ilist_pkg::ST_OK))
      |-> (7'(out_item_o.found_index) < out_item_o.element_count))
    else $error("found index at or above element count");

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI  = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned CHURN_ITEMS = 900;
  localparam int unsigned NOISE_ITEMS = 130;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  ilist_pkg::in_item_t  in_item_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  ilist_pkg::out_item_t out_item_o;

  logic [31:0]          model_cells [ilist_pkg::CAPACITY];
  int unsigned          model_count;
  ilist_pkg::out_item_t awaited_results [$];
  int unsigned          fail_count;
  int unsigned          cycle_count;
  int unsigned          stall_left;
  int unsigned          stall_roll;
  bit                   no_idle;

  indexed_list_insert_remove_find dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one operation to the list model and return the answer it gives.
  function automatic ilist_pkg::out_item_t apply_to_list(ilist_pkg::in_item_t item);
    ilist_pkg::out_item_t res;
    int unsigned          pos;
    bit                   hit;
    logic [6:0]           idx;
    logic [31:0]          val;
    res = '0;
    hit = 1'b0;
    idx = item.element_index;
    val = item.element_value;
    res.status = ilist_pkg::ST_OK;
    case (item.operation)
      ilist_pkg::OP_READ: begin
        if (idx < model_count) res.result_value = model_cells[idx[5:0]];
        else res.status = ilist_pkg::ST_RANGE;
      end
      ilist_pkg::OP_WRITE: begin
        if (idx < model_count) model_cells[idx[5:0]] = val;
        else res.status = ilist_pkg::ST_RANGE;
      end
      ilist_pkg::OP_INSERT: begin
        if (idx > model_count) begin
          res.status = ilist_pkg::ST_RANGE;
        end else if (model_count >= ilist_pkg::CAPACITY) begin
          res.status = ilist_pkg::ST_FULL;
        end else begin
          for (pos = model_count; pos > idx; pos--)
            model_cells[pos[5:0]] = model_cells[6'(pos - 1)];
          model_cells[idx[5:0]] = val;
          model_count++;
        end
      end
      ilist_pkg::OP_REMOVE: begin
        if (idx < model_count) begin
          res.result_value = model_cells[idx[5:0]];
          for (pos = idx; pos + 1 < model_count; pos++)
            model_cells[pos[5:0]] = model_cells[6'(pos + 1)];
          model_count--;
        end else begin
          res.status = ilist_pkg::ST_RANGE;
        end
      end
      ilist_pkg::OP_FIND: begin
        res.status = ilist_pkg::ST_MISSING;
        for (pos = 0; pos < model_count; pos++) begin
          if (!hit && model_cells[pos[5:0]] == val) begin
            hit = 1'b1;
            res.status = ilist_pkg::ST_OK;
            res.found_index = pos[5:0];
          end
        end
      end
      default: ;
    endcase
    res.element_count = model_count[6:0];
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_op(logic [2:0] op, logic [6:0] idx, logic [31:0] val);
    ilist_pkg::in_item_t item;
    int unsigned         gap;
    item.operation     = op;
    item.element_index = idx;
    item.element_value = val;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_item_i  <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    awaited_results.push_back(apply_to_list(item));
  endtask

  task automatic check_result(ilist_pkg::out_item_t got);
    ilist_pkg::out_item_t want;
    if (awaited_results.size() == 0) begin
      $error("unexpected result transaction: status %0d value %h index %0d count %0d",
             got.status, got.result_value, got.found_index, got.element_count);
      fail_count++;
      return;
    end
    want = awaited_results.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      fail_count++;
    end
    if (got.result_value !== want.result_value) begin
      $error("result_value: expected %h, got %h", want.result_value, got.result_value);
      fail_count++;
    end
    if (got.found_index !== want.found_index) begin
      $error("found_index: expected %0d, got %0d", want.found_index, got.found_index);
      fail_count++;
    end
    if (got.element_count !== want.element_count) begin
      $error("element_count: expected %0d, got %0d", want.element_count, got.element_count);
      fail_count++;
    end
  endtask

  // Sample the result channel, then choose the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result(out_item_o);
    if (!rst_ni || no_idle) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 70) begin
        out_stall_i <= 1'b0;
      end else begin
        stall_left = (stall_roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        out_stall_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 7);
    if (r < 55 && model_count != 0)
      return model_cells[6'($urandom_range(0, model_count - 1))];
    return $urandom;
  endfunction

  task automatic test_empty_list();
    send_op(ilist_pkg::OP_READ, 7'd0, 32'h0);
    send_op(ilist_pkg::OP_WRITE, 7'd0, 32'h1);
    send_op(ilist_pkg::OP_REMOVE, 7'd0, 32'h0);
    send_op(ilist_pkg::OP_FIND, 7'd0, 32'h0);
    send_op(ilist_pkg::OP_INSERT, 7'd1, 32'h2);
    send_op(OP_UNUSED_LO, 7'd0, 32'hFFFF_FFFF);
    send_op(OP_UNUSED_MID, 7'd127, 32'h0);
    send_op(OP_UNUSED_HI, 7'd64, 32'h5555_AAAA);
  endtask

  task automatic test_insert_search_remove();
    send_op(ilist_pkg::OP_INSERT, 7'd0, 32'hFFFF_FFFF);
    send_op(ilist_pkg::OP_INSERT, 7'd1, 32'h0000_0000);
    send_op(ilist_pkg::OP_INSERT, 7'd0, 32'h1234_5678);
    send_op(ilist_pkg::OP_INSERT, 7'd1, 32'hA5A5_A5A5);
    send_op(ilist_pkg::OP_READ, 7'd0, 32'h0);
    send_op(ilist_pkg::OP_READ, 7'd3, 32'h0);
    send_op(ilist_pkg::OP_READ, 7'd4, 32'h0);
    send_op(ilist_pkg::OP_WRITE, 7'd2, 32'h0000_0000);
    // two equal entries: the lower position must win
    send_op(ilist_pkg::OP_FIND, 7'd99, 32'h0000_0000);
    send_op(ilist_pkg::OP_FIND, 7'd0, 32'hDEAD_BEEF);
    send_op(ilist_pkg::OP_READ, 7'd127, 32'h0);
    send_op(ilist_pkg::OP_REMOVE, 7'd1, 32'h0);
    send_op(ilist_pkg::OP_REMOVE, 7'd2, 32'h0);
    send_op(ilist_pkg::OP_REMOVE, 7'd5, 32'h0);
    send_op(ilist_pkg::OP_INSERT, 7'd127, 32'h8000_0001);
    send_op(ilist_pkg::OP_INSERT, 7'd2, 32'h8000_0001);
  endtask

  // Grow the list to capacity, push against the full list, then drain it, and repeat.
  task automatic test_random_churn(int unsigned n_items);
    int unsigned k;
    int unsigned r;
    int unsigned at_full;
    bit          growing;
    logic [2:0]  op;
    logic [6:0]  idx;
    growing = 1'b1;
    at_full = 0;
    for (k = 0; k < n_items; k++) begin
      if (k % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (growing && model_count == ilist_pkg::CAPACITY) begin
        at_full++;
        if (at_full > 6) begin
          growing = 1'b0;
          at_full = 0;
        end
      end else if (!growing && model_count == 0) begin
        growing = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 55) op = growing ? ilist_pkg::OP_INSERT : ilist_pkg::OP_REMOVE;
      else if (r < 70) op = growing ? ilist_pkg::OP_REMOVE : ilist_pkg::OP_INSERT;
      else if (r < 80) op = ilist_pkg::OP_READ;
      else if (r < 88) op = ilist_pkg::OP_WRITE;
      else op = ilist_pkg::OP_FIND;
      if ($urandom_range(0, 9) == 0) idx = 7'($urandom_range(0, 127));
      else if (op == ilist_pkg::OP_INSERT) idx = 7'($urandom_range(0, model_count));
      else if (model_count != 0) idx = 7'($urandom_range(0, model_count - 1));
      else idx = 7'd0;
      send_op(op, idx, pick_value());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_noise(int unsigned n_items);
    int unsigned k;
    for (k = 0; k < n_items; k++)
      send_op(3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)), $urandom);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;
    model_count = 0;
    fail_count  = 0;
    cycle_count = 0;
    stall_left  = 0;
    no_idle     = 1'b0;
    foreach (model_cells[i]) model_cells[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_insert_search_remove();
    test_random_churn(CHURN_ITEMS);
    test_noise(NOISE_ITEMS);

    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    // let any stray result show up
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
